// ===== sv/nrt_pkg.sv =====
// ---------------------------------------------------------------------------
// nrt_pkg: shared definitions for the nonce request table
// Sizes, operation and status codes, the stored entry layout and the
// summary that the scan unit hands to the control logic.
// ---------------------------------------------------------------------------
package nrt_pkg;

  localparam int ENTRIES  = 32;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int SLOT_W   = 5;
  localparam int STAMP_W  = 32;
  localparam int NHIGH_W  = 32;
  localparam int NLOW_W   = 64;
  localparam int AGE_W    = 16;

  localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = 16'd10;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_LOOKUP  = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_DUP      = 2'd1;
  localparam logic [1:0] STAT_BUSY     = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [NHIGH_W-1:0] nonce_high;
    logic [NLOW_W-1:0]  nonce_low;
    logic               tp_flag;
  } entry_t;

  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic               hit_tp;
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic               old_found;
    logic [IDX_W-1:0]   old_idx;
    logic [STAMP_W-1:0] old_stamp;
  } scan_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Low SLOT_W bits of an entry index, zero-extended for small tables.
  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, idx};
    return wide[SLOT_W-1:0];
  endfunction

endpackage

// ===== sv/nrt_entry_ram.sv =====
// ---------------------------------------------------------------------------
// nrt_entry_ram: entry storage
// One write port and one read port; read data is registered, so it
// appears in the cycle after the address.
// ---------------------------------------------------------------------------
module nrt_entry_ram
  import nrt_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data
);

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/nrt_scan.sv =====
// ---------------------------------------------------------------------------
// nrt_scan: per-entry search accumulator
// Looks at one entry per cycle and keeps the first live nonce match, the
// first free entry and the oldest live entry that has aged out.
// ---------------------------------------------------------------------------
module nrt_scan
  import nrt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic               rd_valid,
  input  logic [IDX_W-1:0]   rd_idx,
  input  logic               rd_live,
  input  entry_t             rd_entry,
  input  logic [NHIGH_W-1:0] key_high,
  input  logic [NLOW_W-1:0]  key_low,
  input  logic [STAMP_W-1:0] now_seconds,
  input  logic [AGE_W-1:0]   age_limit,
  output scan_res_t          result
);

  scan_res_t          result_next;
  logic               match;
  logic               aged;
  logic [STAMP_W:0]   expire;

  always_comb begin
    match  = rd_live && (rd_entry.nonce_high == key_high) &&
             (rd_entry.nonce_low == key_low);
    // Sum kept one bit wider so it cannot wrap.
    expire = {1'b0, rd_entry.stamp} + {{(STAMP_W + 1 - AGE_W){1'b0}}, age_limit};
    aged   = rd_live && (expire < {1'b0, now_seconds});

    result_next = result;
    if (rd_valid) begin
      if (match && !result.hit) begin
        result_next.hit     = 1'b1;
        result_next.hit_idx = rd_idx;
        result_next.hit_tp  = rd_entry.tp_flag;
      end
      if (!rd_live && !result.free_found) begin
        result_next.free_found = 1'b1;
        result_next.free_idx   = rd_idx;
      end
      // Strict compare keeps the lowest index among equal stamps.
      if (aged && (!result.old_found || rd_entry.stamp < result.old_stamp)) begin
        result_next.old_found = 1'b1;
        result_next.old_idx   = rd_idx;
        result_next.old_stamp = rd_entry.stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      result <= '0;
    end else begin
      result <= result_next;
    end
  end

endmodule

// ===== sv/nonce_request_table_top.sv =====
// ---------------------------------------------------------------------------
// nonce_request_table_top: pending request table keyed by a 96-bit nonce
// Allocate, lookup and lookup-and-release over a table of timestamped
// entries, with replacement of entries older than a programmable limit.
// ---------------------------------------------------------------------------
// Each request beat runs from acceptance to its result as follows: every
// table entry is read from the entry memory through its single read port
// in turn (ENTRIES reads, the first one issued in the cycle after the beat
// is captured), the last read returns in the drain state, and the finish
// state decides, updates the table and loads the result register. The input
// stalls for the whole walk and reopens in the cycle after the result is
// loaded, so a new beat is not taken until the previous one has finished,
// and a new beat can be taken while the previous result is still waiting
// downstream. A result that is held by a stall on the output also holds the
// decision cycle of the next beat. Entry liveness is kept in a flip-flop
// vector that reset clears at once, so no clearing pass is needed and the
// block is ready in the cycle after reset. The age limit must only be
// written while no beat is in progress.
// ---------------------------------------------------------------------------
module nonce_request_table_top
  import nrt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Configuration
  input  logic                cfg_write_en,
  input  logic [AGE_W-1:0]    cfg_write_data,
  // Request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          mode,
  input  logic [NHIGH_W-1:0]  nonce_high,
  input  logic [NLOW_W-1:0]   nonce_low,
  input  logic [STAMP_W-1:0]  now_seconds,
  input  logic                third_party_in,
  // Result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [SLOT_W-1:0]   slot,
  output logic                third_party_out
);

  // Programmable age limit.
  logic [AGE_W-1:0] age_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      age_limit <= AGE_LIMIT_RESET;
    end else if (cfg_write_en) begin
      age_limit <= cfg_write_data;
    end
  end

  // Captured request beat.
  logic [1:0]         req_mode;
  logic [NHIGH_W-1:0] req_nonce_high;
  logic [NLOW_W-1:0]  req_nonce_low;
  logic [STAMP_W-1:0] req_now;
  logic               req_tp;

  state_t             state;
  state_t             state_next;
  logic [IDX_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   scan_idx_next;
  logic               rd_pending;
  logic [IDX_W-1:0]   rd_idx;
  logic               rd_live;
  logic [ENTRIES-1:0] live;
  logic [ENTRIES-1:0] live_next;

  logic               accept;
  logic               issue;
  logic               finish;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  entry_t             rd_entry;
  scan_res_t          scan_res;

  logic [1:0]         res_status;
  logic [SLOT_W-1:0]  res_slot;
  logic               res_tp;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode       <= mode;
      req_nonce_high <= nonce_high;
      req_nonce_low  <= nonce_low;
      req_now        <= now_seconds;
      req_tp         <= third_party_in;
    end
  end

  // Control sequencer: walk every entry, then decide and write back.
  always_comb begin
    state_next    = state;
    scan_idx_next = scan_idx;
    in_stall      = 1'b1;
    issue         = 1'b0;
    finish        = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next    = ST_SCAN;
          scan_idx_next = '0;
        end
      end
      ST_SCAN: begin
        issue         = 1'b1;
        scan_idx_next = scan_idx + 1'b1;
        if (scan_idx == IDX_W'(ENTRIES - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // Wait until the result register can take the new beat.
        if (!out_valid || !out_stall) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_idx   <= '0;
      rd_pending <= 1'b0;
      live       <= '0;
    end else begin
      state      <= state_next;
      scan_idx   <= scan_idx_next;
      rd_pending <= issue;
      live       <= live_next;
    end
  end

  // Liveness travels alongside the memory read so both line up.
  always_ff @(posedge clk) begin
    rd_idx  <= scan_idx;
    rd_live <= live[scan_idx];
  end

  nrt_entry_ram u_ram (
    .clk     (clk),
    .rd_addr (scan_idx),
    .rd_data (rd_entry),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  nrt_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .clear       (accept),
    .rd_valid    (rd_pending),
    .rd_idx      (rd_idx),
    .rd_live     (rd_live),
    .rd_entry    (rd_entry),
    .key_high    (req_nonce_high),
    .key_low     (req_nonce_low),
    .now_seconds (req_now),
    .age_limit   (age_limit),
    .result      (scan_res)
  );

  // Decision and table update. A release only drops the live bit; the
  // stored entry is left in place and is never compared while dead.
  always_comb begin
    res_status       = STAT_NOTFOUND;
    res_slot         = '0;
    res_tp           = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = scan_res.free_idx;
    wr_data.stamp    = (req_now == '0) ? STAMP_W'(1) : req_now;
    wr_data.nonce_high  = req_nonce_high;
    wr_data.nonce_low   = req_nonce_low;
    wr_data.tp_flag     = req_tp;
    live_next        = live;

    if (req_mode == MODE_ALLOC) begin
      if (scan_res.hit) begin
        res_status = STAT_DUP;
        res_slot   = to_slot(scan_res.hit_idx);
        res_tp     = scan_res.hit_tp;
      end else if (scan_res.free_found || scan_res.old_found) begin
        // A free entry always wins over an aged-out one.
        wr_addr    = scan_res.free_found ? scan_res.free_idx : scan_res.old_idx;
        res_status = STAT_OK;
        res_slot   = to_slot(wr_addr);
        res_tp     = req_tp;
        if (finish) begin
          wr_en              = 1'b1;
          live_next[wr_addr] = 1'b1;
        end
      end else begin
        res_status = STAT_BUSY;
      end
    end else if (scan_res.hit) begin
      res_status = STAT_OK;
      res_slot   = to_slot(scan_res.hit_idx);
      res_tp     = scan_res.hit_tp;
      if (finish && req_mode == MODE_RELEASE) begin
        live_next[scan_res.hit_idx] = 1'b0;
      end
    end
  end

  // Result register: frees the request side from the result side.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status          <= res_status;
      slot            <= res_slot;
      third_party_out <= res_tp;
    end
  end

`ifndef SYNTH
  // A new result only appears after a decision cycle.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result appeared without a decision cycle");

  // The entry memory is written only by a successful allocation.
  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_FINISH && req_mode == MODE_ALLOC && res_status == STAT_OK))
    else $error("entry write outside an allocation");

  // At most one entry changes liveness per beat.
  assert property (@(posedge clk) disable iff (rst)
    $countones(live ^ $past(live)) <= 1)
    else $error("more than one live bit changed");

  // An accepted beat always starts a full walk from the first entry.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SCAN && scan_idx == '0))
    else $error("walk did not start at entry zero");

  // Live bits only change when a beat completes.
  assert property (@(posedge clk) disable iff (rst)
    (live != $past(live)) |-> $past(finish))
    else $error("live bits changed outside a decision");
`endif

endmodule
